// ----- rtl/core/roiwpg_pkg.sv -----
// shared types and constants for the region window and proximity grouping block
package roiwpg_pkg;

    // coordinate widths: pixels, and half-pixel midpoints
    localparam int COORD_BITS = 13;
    localparam int HALF_BITS  = COORD_BITS + 1;

    // configuration register widths
    localparam int SIZE_BITS  = 14;
    localparam int HWIN_BITS  = 12;
    localparam int MDIST_BITS = 14;
    localparam int LIM_BITS   = MDIST_BITS + 1;

    // result field widths
    localparam int GROUP_BITS  = 6;
    localparam int MEMBER_BITS = 16;

    // configuration port widths
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    // signed working width of the window clamp
    localparam int CALC_BITS = 18;

    // default group table depth
    localparam int MAX_GROUPS_DEF = 64;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH   = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_HEIGHT  = 8'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_DIST   = 8'd4;

    // register reset values
    localparam logic [SIZE_BITS-1:0]  RST_IMAGE_WIDTH  = 14'd1920;
    localparam logic [SIZE_BITS-1:0]  RST_IMAGE_HEIGHT = 14'd1080;
    localparam logic [HWIN_BITS-1:0]  RST_HALF_WIDTH   = 12'd32;
    localparam logic [HWIN_BITS-1:0]  RST_HALF_HEIGHT  = 12'd32;
    localparam logic [MDIST_BITS-1:0] RST_MATCH_DIST   = 14'd16;

    // input word: one marked segment
    typedef struct packed {
        logic [COORD_BITS-1:0] seg_x_start;
        logic [COORD_BITS-1:0] seg_y_start;
        logic [COORD_BITS-1:0] seg_x_end;
        logic [COORD_BITS-1:0] seg_y_end;
    } t_seg;

    // result word
    typedef struct packed {
        logic [COORD_BITS-1:0]  window_left;
        logic [COORD_BITS-1:0]  window_top;
        logic [GROUP_BITS-1:0]  group_number;
        logic [MEMBER_BITS-1:0] member_number;
        logic                   opened_group;
        logic                   table_full;
    } t_result;

    // search token handed from cell to cell
    typedef struct packed {
        logic                   valid;
        logic                   found;
        logic [HALF_BITS-1:0]   x2;
        logic [HALF_BITS-1:0]   y2;
        logic [GROUP_BITS-1:0]  group;
        logic [MEMBER_BITS-1:0] member;
    } t_query;

    // anchor written into a cell when a group is opened
    typedef struct packed {
        logic                 en;
        logic [HALF_BITS-1:0] x2;
        logic [HALF_BITS-1:0] y2;
    } t_open;

endpackage

// ----- rtl/core/roiwpg_cell.sv -----
// one group cell: anchor, member count and one stage of the search token
module roiwpg_cell
    import roiwpg_pkg::*;
#(
    parameter int IDX = 0,
    parameter int UW  = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_query              i_q,
    output t_query              o_q,
    input  logic [UW-1:0]       i_used,
    input  logic [LIM_BITS-1:0] i_lim2,
    input  t_open               i_open
);

    logic [HALF_BITS-1:0]   r_ax2;
    logic [HALF_BITS-1:0]   r_ay2;
    logic [MEMBER_BITS-1:0] r_count;
    t_query                 r_q;
    t_query                 n_q;
    logic [HALF_BITS-1:0]   w_dx;
    logic [HALF_BITS-1:0]   w_dy;
    logic                   w_open_group;
    logic                   w_match;

    // per-axis distance to the anchor in half pixels
    assign w_dx = (i_q.x2 > r_ax2) ? (i_q.x2 - r_ax2) : (r_ax2 - i_q.x2);
    assign w_dy = (i_q.y2 > r_ay2) ? (i_q.y2 - r_ay2) : (r_ay2 - i_q.y2);

    // only open groups take part
    assign w_open_group = UW'(IDX) < i_used;

    assign w_match = i_q.valid && !i_q.found && w_open_group
                     && (LIM_BITS'(w_dx) < i_lim2) && (LIM_BITS'(w_dy) < i_lim2);

    // token to the next cell
    always_comb begin
        n_q = i_q;
        if (w_match) begin
            n_q.found  = 1'b1;
            n_q.group  = GROUP_BITS'(IDX);
            n_q.member = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    // anchor and saturating member count
    always_ff @(posedge i_clk) begin
        if (i_open.en) begin
            r_ax2   <= i_open.x2;
            r_ay2   <= i_open.y2;
            r_count <= MEMBER_BITS'(1);
        end else if (w_match && (r_count != '1)) begin
            r_count <= r_count + MEMBER_BITS'(1);
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/roi_window_and_proximity_grouping.sv -----
// top level: window clamp, configuration registers and the chain of group cells
//
// One segment is taken when start is high and busy is low. Its result word
// appears on o_result with o_strobe high for exactly one cycle, once the search
// token has passed every group cell and the result register; there is no
// back-pressure, so the receiver must take it in that cycle. busy drops in the
// strobe cycle, so a new segment can be started then; a new segment is not
// taken while the search token of the last one is still in the row of group
// cells, which it walks one cell per clock. No clearing pass is needed after
// reset: the open-group count alone decides which cells take part. Configuration
// writes are always accepted and must only be issued while busy is low and no
// segment is being started.
module roi_window_and_proximity_grouping
    import roiwpg_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_seg                     i_seg,
    output t_result                  o_result,
    output logic                     o_strobe,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int UW = $clog2(MAX_GROUPS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                  r_state;
    logic [SIZE_BITS-1:0]    r_img_w;
    logic [SIZE_BITS-1:0]    r_img_h;
    logic [HWIN_BITS-1:0]    r_half_w;
    logic [HWIN_BITS-1:0]    r_half_h;
    logic [MDIST_BITS-1:0]   r_match;
    logic [UW-1:0]           r_used;
    logic [HALF_BITS-1:0]    r_mx2;
    logic [HALF_BITS-1:0]    r_my2;
    logic [COORD_BITS-1:0]   r_left;
    logic [COORD_BITS-1:0]   r_top;
    t_result                 r_out;
    logic                    r_strobe;
    logic                    w_accept;
    logic [HALF_BITS-1:0]    w_mx2;
    logic [HALF_BITS-1:0]    w_my2;
    logic [LIM_BITS-1:0]     w_lim2;
    t_query                  w_q [MAX_GROUPS+1];
    t_query                  w_exit;
    logic                    w_do_open;
    logic                    w_is_full;

    // clamp one axis; returns the low edge in whole pixels
    function automatic logic [COORD_BITS-1:0] f_clamp(
        input logic [HALF_BITS-1:0] mid2,
        input logic [HWIN_BITS-1:0] half,
        input logic [SIZE_BITS-1:0] size
    );
        logic signed [CALC_BITS-1:0] lo2;
        logic signed [CALC_BITS-1:0] hi2;
        logic signed [CALC_BITS-1:0] edge2;
        logic signed [CALC_BITS-1:0] h2;
        lo2   = '0;
        h2    = $signed(CALC_BITS'(half) <<< 1);
        edge2 = $signed(CALC_BITS'(size) <<< 1);
        lo2   = $signed(CALC_BITS'(mid2)) - h2;
        hi2   = $signed(CALC_BITS'(mid2)) + h2;
        if (hi2 > edge2) begin
            lo2 = edge2 - (h2 <<< 1);
        end
        if (lo2 < 0) begin
            lo2 = '0;
        end
        return lo2[COORD_BITS:1];
    endfunction

    assign w_accept = start && !busy;
    assign busy     = (r_state == S_SCAN);

    // midpoints in half pixels
    assign w_mx2  = HALF_BITS'(i_seg.seg_x_start) + HALF_BITS'(i_seg.seg_x_end);
    assign w_my2  = HALF_BITS'(i_seg.seg_y_start) + HALF_BITS'(i_seg.seg_y_end);
    assign w_lim2 = {r_match, 1'b0};

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= RST_IMAGE_WIDTH;
            r_img_h  <= RST_IMAGE_HEIGHT;
            r_half_w <= RST_HALF_WIDTH;
            r_half_h <= RST_HALF_HEIGHT;
            r_match  <= RST_MATCH_DIST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[SIZE_BITS-1:0];
                REG_HALF_WIDTH:   r_half_w <= i_cfg_data[HWIN_BITS-1:0];
                REG_HALF_HEIGHT:  r_half_h <= i_cfg_data[HWIN_BITS-1:0];
                REG_MATCH_DIST:   r_match  <= i_cfg_data[MDIST_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // token injected into the first cell
    always_comb begin
        w_q[0]        = '0;
        w_q[0].valid  = w_accept;
        w_q[0].x2     = w_mx2;
        w_q[0].y2     = w_my2;
    end

    // row of group cells
    for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
        t_open w_open;

        always_comb begin
            w_open.en = w_do_open && (r_used == UW'(g));
            w_open.x2 = r_mx2;
            w_open.y2 = r_my2;
        end

        roiwpg_cell #(
            .IDX (g),
            .UW  (UW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_q     (w_q[g]),
            .o_q     (w_q[g+1]),
            .i_used  (r_used),
            .i_lim2  (w_lim2),
            .i_open  (w_open)
        );
    end

    assign w_exit    = w_q[MAX_GROUPS];
    assign w_do_open = w_exit.valid && !w_exit.found && (r_used < UW'(MAX_GROUPS));
    assign w_is_full = w_exit.valid && !w_exit.found && (r_used == UW'(MAX_GROUPS));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_exit.valid) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // open-group count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_do_open) begin
            r_used <= r_used + UW'(1);
        end
    end

    // midpoint hold and window clamp, both taken with the segment
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mx2  <= w_mx2;
            r_my2  <= w_my2;
            r_left <= f_clamp(w_mx2, r_half_w, r_img_w);
            r_top  <= f_clamp(w_my2, r_half_h, r_img_h);
        end
    end

    // result word and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_exit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit.valid) begin
            r_out.window_left   <= r_left;
            r_out.window_top    <= r_top;
            r_out.opened_group  <= w_do_open;
            r_out.table_full    <= w_is_full;
            if (w_exit.found) begin
                r_out.group_number  <= w_exit.group;
                r_out.member_number <= w_exit.member;
            end else if (w_do_open) begin
                r_out.group_number  <= GROUP_BITS'(r_used);
                r_out.member_number <= '0;
            end else begin
                r_out.group_number  <= '0;
                r_out.member_number <= '0;
            end
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

    // a result only follows a running search
    a_strobe_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a search in progress");

    // a result never both opens a group and reports a full table
    a_open_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.opened_group && o_result.table_full))
        else $error("opened group and full table in one result");

    // the open-group count stays within the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_GROUPS))
        else $error("open-group count beyond table depth");

    // opening a group advances the count by exactly one
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_open |=> (r_used == $past(r_used) + UW'(1)))
        else $error("open-group count did not advance on opening");

endmodule
